@@ src/watm_pkg.sv @@
// ----------------------------------------------------------------------------
// watm_pkg
// Types and constants shared by the weekly alarm table matcher modules.
// ----------------------------------------------------------------------------
package watm_pkg;

    // Operation codes carried on the input channel
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_BUTTON = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;

    // Day mask encoding
    localparam logic [7:0] EMPTY_MASK = 8'hFF;
    localparam logic [7:0] ALL_DAYS   = 8'h7F;
    localparam int         REPEAT_BIT = 7;
    localparam logic [7:0] SUNDAY_BIT = 8'b0100_0000;
    localparam logic [7:0] DAY_LSB    = 8'b0000_0001;

    // Display phase wraps after this many steps
    localparam logic [1:0] PHASE_MODULO = 2'd3;

    // Command queue depth between front and back
    localparam int FIFO_DEPTH = 2;

    // Input beat
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] alarm_days;
        logic [7:0] alarm_hour;
        logic [7:0] alarm_minute;
        logic [7:0] slot_index;
        logic [5:0] now_seconds;
        logic [5:0] now_minutes;
        logic [4:0] now_hours;
        logic [2:0] now_weekday;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [1:0] status;
        logic       alarm_active;
        logic       buzzer;
        logic [1:0] display_phase;
        logic       entry_valid;
        logic [3:0] entry_index;
        logic [7:0] entry_days;
        logic [7:0] entry_hour;
        logic [7:0] entry_minute;
        logic       last;
    } res_t;

    // Decoded command kinds
    typedef enum logic [2:0] {
        CMD_ADD,
        CMD_REMOVE,
        CMD_TICK,
        CMD_BUTTON,
        CMD_LIST,
        CMD_NOP
    } cmd_kind_t;

    // Classified command handed from front to back
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] days;      // 255 already folded to all days
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] slot;
        logic       sec_zero;
        logic       sec_even;
        logic [5:0] now_min;
        logic [4:0] now_hr;
        logic [7:0] day_sel;   // one-hot mask bit of today, zero if weekday bad
    } cmd_t;

    // One table entry
    typedef struct packed {
        logic [7:0] days;
        logic [7:0] hour;
        logic [7:0] minute;
    } entry_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_RESP,
        ST_LIST_END
    } back_state_t;

endpackage

@@ src/watm_fifo.sv @@
// ----------------------------------------------------------------------------
// watm_fifo
// Short command queue that decouples the front decoder from the back engine.
// ----------------------------------------------------------------------------
module watm_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  watm_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output watm_pkg::cmd_t pop_data
);

    localparam int PTR_W = (watm_pkg::FIFO_DEPTH > 1) ? $clog2(watm_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(watm_pkg::FIFO_DEPTH + 1);

    watm_pkg::cmd_t slots_reg [watm_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(watm_pkg::FIFO_DEPTH));
    assign avail    = (count_reg != '0);
    assign pop_data = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && avail;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(watm_pkg::FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(watm_pkg::FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/watm_front.sv @@
// ----------------------------------------------------------------------------
// watm_front
// Accepts input beats, decodes the operation and precomputes tick terms.
// ----------------------------------------------------------------------------
module watm_front (
    input  logic           s_valid,
    output logic           s_ready,
    input  watm_pkg::in_t  s_data,
    output logic           push,
    output watm_pkg::cmd_t push_data,
    input  logic           full
);

    logic [2:0] day_shift;

    assign s_ready = !full;
    assign push    = s_valid && !full;

    // Weekday 1..7 maps to mask bits 6..0
    assign day_shift = 3'd7 - s_data.now_weekday;

    // Classify the beat
    always_comb begin
        push_data = '0;
        case (s_data.op)
            watm_pkg::OP_ADD:    push_data.kind = watm_pkg::CMD_ADD;
            watm_pkg::OP_REMOVE: push_data.kind = watm_pkg::CMD_REMOVE;
            watm_pkg::OP_TICK:   push_data.kind = watm_pkg::CMD_TICK;
            watm_pkg::OP_BUTTON: push_data.kind = watm_pkg::CMD_BUTTON;
            watm_pkg::OP_LIST:   push_data.kind = watm_pkg::CMD_LIST;
            default:             push_data.kind = watm_pkg::CMD_NOP;
        endcase
        push_data.days     = (s_data.alarm_days == watm_pkg::EMPTY_MASK) ?
                             watm_pkg::ALL_DAYS : s_data.alarm_days;
        push_data.hour     = s_data.alarm_hour;
        push_data.minute   = s_data.alarm_minute;
        push_data.slot     = s_data.slot_index;
        push_data.sec_zero = (s_data.now_seconds == 6'd0);
        push_data.sec_even = !s_data.now_seconds[0];
        push_data.now_min  = s_data.now_minutes;
        push_data.now_hr   = s_data.now_hours;
        // Weekday zero never matches; 1..7 selects Sunday..Saturday
        if (s_data.now_weekday != 3'd0) begin
            push_data.day_sel = watm_pkg::DAY_LSB << day_shift;
        end
    end

endmodule

@@ src/watm_back.sv @@
// ----------------------------------------------------------------------------
// watm_back
// Alarm table engine: walks the table one slot per step, owns the ringing
// flag, display phase and the result output register.
// ----------------------------------------------------------------------------
module watm_back #(
    parameter int ENTRIES = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_avail,
    input  watm_pkg::cmd_t cmd_data,
    output logic           cmd_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output watm_pkg::res_t m_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    watm_pkg::back_state_t state_reg, state_next;
    watm_pkg::cmd_t        cmd_reg, cmd_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic                  ring_reg, ring_next;
    logic [1:0]            phase_reg, phase_next;
    logic [1:0]            status_reg, status_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    watm_pkg::entry_t      pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    watm_pkg::res_t        m_data_reg, m_data_next;

    watm_pkg::entry_t      mem [ENTRIES];
    watm_pkg::entry_t      rd_data_reg;
    watm_pkg::entry_t      wr_entry;
    logic                  mem_we;

    logic                  out_free;
    logic                  hit;
    logic                  repeats;
    logic [6:0]            day_bits;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign wr_entry = '{days: cmd_reg.days, hour: cmd_reg.hour, minute: cmd_reg.minute};

    // Match terms for the entry read out in the previous step
    assign day_bits = rd_data_reg.days[6:0];
    assign hit      = ((rd_data_reg.days & cmd_reg.day_sel) != 8'd0) &&
                      (rd_data_reg.hour == {3'd0, cmd_reg.now_hr}) &&
                      (rd_data_reg.minute == {2'd0, cmd_reg.now_min});
    assign repeats  = rd_data_reg.days[watm_pkg::REPEAT_BIT] ||
                      ((day_bits & (day_bits - 7'd1)) != 7'd0);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        ring_next       = ring_reg;
        phase_next      = phase_reg;
        status_next     = status_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_next       = pend_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;

        case (state_reg)
            watm_pkg::ST_IDLE: begin
                if (cmd_avail) begin
                    cmd_pop         = 1'b1;
                    cmd_next        = cmd_data;
                    idx_next        = '0;
                    status_next     = watm_pkg::STATUS_DONE;
                    pend_valid_next = 1'b0;
                    state_next      = watm_pkg::ST_RESP;
                    case (cmd_data.kind)
                        watm_pkg::CMD_ADD, watm_pkg::CMD_LIST: begin
                            state_next = watm_pkg::ST_SCAN;
                        end
                        watm_pkg::CMD_TICK: begin
                            if (cmd_data.sec_zero && !ring_reg) begin
                                state_next = watm_pkg::ST_SCAN;
                            end
                        end
                        watm_pkg::CMD_REMOVE: begin
                            if ((cmd_data.slot < 8'(ENTRIES)) &&
                                valid_reg[cmd_data.slot[IDX_W-1:0]]) begin
                                valid_next[cmd_data.slot[IDX_W-1:0]] = 1'b0;
                            end else begin
                                status_next = watm_pkg::STATUS_BAD_SLOT;
                            end
                        end
                        watm_pkg::CMD_BUTTON: begin
                            if (ring_reg) begin
                                ring_next = 1'b0;
                            end else begin
                                phase_next = (phase_reg == watm_pkg::PHASE_MODULO - 2'd1) ?
                                             2'd0 : phase_reg + 2'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            watm_pkg::ST_SCAN: begin
                if (cmd_reg.kind == watm_pkg::CMD_ADD) begin
                    // First free slot takes the new alarm
                    if (!valid_reg[idx_reg]) begin
                        mem_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        state_next          = watm_pkg::ST_RESP;
                    end else if (idx_reg == LAST_IDX) begin
                        status_next = watm_pkg::STATUS_FULL;
                        state_next  = watm_pkg::ST_RESP;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    // Tick and list read only occupied slots
                    if (valid_reg[idx_reg]) begin
                        state_next = watm_pkg::ST_EVAL;
                    end else if (idx_reg == LAST_IDX) begin
                        state_next = (cmd_reg.kind == watm_pkg::CMD_LIST) ?
                                     watm_pkg::ST_LIST_END : watm_pkg::ST_RESP;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            watm_pkg::ST_EVAL: begin
                if (cmd_reg.kind == watm_pkg::CMD_LIST) begin
                    // Held entry goes out once the next one is known
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_valid_next              = 1'b1;
                            m_data_next               = '0;
                            m_data_next.status        = watm_pkg::STATUS_DONE;
                            m_data_next.alarm_active  = ring_reg;
                            m_data_next.display_phase = phase_reg;
                            m_data_next.entry_valid   = 1'b1;
                            m_data_next.entry_index   = 4'(pend_idx_reg);
                            m_data_next.entry_days    = pend_reg.days;
                            m_data_next.entry_hour    = pend_reg.hour;
                            m_data_next.entry_minute  = pend_reg.minute;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                        pend_next       = rd_data_reg;
                        if (idx_reg == LAST_IDX) begin
                            state_next = watm_pkg::ST_LIST_END;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = watm_pkg::ST_SCAN;
                        end
                    end
                end else begin
                    // Tick match; one-shot alarms are erased on hit
                    if (hit) begin
                        ring_next = 1'b1;
                        if (!repeats) begin
                            valid_next[idx_reg] = 1'b0;
                        end
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = watm_pkg::ST_RESP;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = watm_pkg::ST_SCAN;
                    end
                end
            end

            watm_pkg::ST_LIST_END: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next               = '0;
                    m_data_next.status        = watm_pkg::STATUS_DONE;
                    m_data_next.alarm_active  = ring_reg;
                    m_data_next.display_phase = phase_reg;
                    m_data_next.last          = 1'b1;
                    if (pend_valid_reg) begin
                        m_data_next.entry_valid  = 1'b1;
                        m_data_next.entry_index  = 4'(pend_idx_reg);
                        m_data_next.entry_days   = pend_reg.days;
                        m_data_next.entry_hour   = pend_reg.hour;
                        m_data_next.entry_minute = pend_reg.minute;
                    end
                    state_next = watm_pkg::ST_IDLE;
                end
            end

            watm_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next               = '0;
                    m_data_next.status        = status_reg;
                    m_data_next.alarm_active  = ring_reg;
                    m_data_next.buzzer        = (cmd_reg.kind == watm_pkg::CMD_TICK) &&
                                                ring_reg && cmd_reg.sec_even;
                    m_data_next.display_phase = phase_reg;
                    m_data_next.last          = 1'b1;
                    state_next                = watm_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = watm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= watm_pkg::ST_IDLE;
            valid_reg      <= '0;
            ring_reg       <= 1'b0;
            phase_reg      <= 2'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            ring_reg       <= ring_next;
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            idx_reg        <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        pend_idx_reg <= pend_idx_next;
        pend_reg     <= pend_next;
        m_data_reg   <= m_data_next;
    end

    // Alarm table memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg] <= wr_entry;
        end
        rd_data_reg <= mem[idx_reg];
    end

endmodule

@@ src/weekly_alarm_table_matcher_core.sv @@
// ----------------------------------------------------------------------------
// weekly_alarm_table_matcher_core
// Weekly alarm table: add, remove, list, time tick matching and button.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one operation per beat (add, remove, tick,
//   button, list). m_valid/m_ready/m_data return result beats; every
//   operation yields one beat, list yields one per stored alarm (or one empty
//   beat), and the final beat of an operation has last set.
//   A front decoder feeds a two-deep command queue, so up to two operations
//   are taken while the engine is busy or the receiver stalls.
//   Remove, button and unknown ops go from idle straight to the result state.
//   Add walks the occupancy bits one slot per step up to the first free slot.
//   Tick (at second 0, not ringing) and list step through the table,
//   with a scan step per empty slot and a scan and an evaluate step per
//   stored slot (registered memory read); list waits while the output stalls.
//   Reset (aresetn low, synchronous) empties the table at once through
//   per-slot occupancy bits, stops the alarm and returns the display to time.
//   While m_ready is low the result beat holds and the engine waits; the
//   input side keeps taking beats until the queue is full.
// ----------------------------------------------------------------------------
module weekly_alarm_table_matcher_core #(
    parameter int ENTRIES = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  watm_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output watm_pkg::res_t m_data
);

    logic           push;
    logic           full;
    logic           pop;
    logic           avail;
    watm_pkg::cmd_t push_data;
    watm_pkg::cmd_t pop_data;

    // Decode
    watm_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Command queue
    watm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .avail     (avail),
        .pop_data  (pop_data)
    );

    // Table engine
    watm_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_avail (avail),
        .cmd_data  (pop_data),
        .cmd_pop   (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
